FILE: hw/rtl/lsse_pkg.sv
// lsse_pkg: shared widths, coefficient tables, types and codes for the
// linear state-space euler step block; used by every rtl file of the block
`default_nettype none

package lsse_pkg;

   localparam int NUM_STATES = 4;
   localparam int ROW_W      = 2;
   localparam int CTRL_W     = 16;
   localparam int STATE_W    = 32;
   localparam int STEP_W     = 16;
   localparam int COEF_W     = 17;
   localparam int PROD_A_W   = COEF_W + STATE_W;
   localparam int PROD_B_W   = COEF_W + CTRL_W;
   localparam int DERIV_W    = 50;
   localparam int D16_W      = 36;
   localparam int SCALED_W   = D16_W + STEP_W + 1;
   localparam int INC_W      = 37;
   localparam int TOTAL_W    = 38;
   localparam int D_SHIFT    = 14;
   localparam int S_SHIFT    = 16;
   localparam int B_SHIFT    = 2;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE = 1'b0;

   localparam logic [STEP_W-1:0] STEP_SIZE_RESET = 16'd2185;

   localparam logic signed [DERIV_W-1:0]  D_HALF = DERIV_W'(8192);
   localparam logic signed [SCALED_W-1:0] S_HALF = SCALED_W'(32768);
   localparam logic signed [TOTAL_W-1:0]  SAT_HI = TOTAL_W'(2147483647);
   localparam logic signed [TOTAL_W-1:0]  SAT_LO = ~SAT_HI;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic [NUM_STATES-1:0][CTRL_W-1:0]  ctrl_vec_type;
   typedef logic [NUM_STATES-1:0][STATE_W-1:0] state_vec_type;

   // head of the word queue as seen by the back end
   typedef struct packed {
      logic         valid;
      ctrl_vec_type ctrl;
   } qhead_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ISSUE  = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } seq_type;

   // Q2.14 coefficients, row major
   localparam coef_type COEF_A [NUM_STATES][NUM_STATES] = '{
      '{-17'sd12625, -17'sd84,    17'sd3711,   17'sd2959},
      '{ 17'sd267,   -17'sd5795, -17'sd4604,   17'sd257},
      '{-17'sd3369,  -17'sd1149, -17'sd20392,  17'sd1519},
      '{-17'sd5192,   17'sd772,  -17'sd624,   -17'sd27838}
   };

   localparam coef_type COEF_B [NUM_STATES][NUM_STATES] = '{
      '{ 17'sd15788, -17'sd1352, -17'sd2448,  -17'sd321},
      '{ 17'sd185,    17'sd16712,-17'sd441,   -17'sd1463},
      '{ 17'sd554,   -17'sd177,   17'sd31080, -17'sd800},
      '{ 17'sd2335,   17'sd436,  -17'sd2310,   17'sd33587}
   };

endpackage

`default_nettype wire

FILE: hw/rtl/lsse_front.sv
// lsse_front: input side, takes control words into a short queue
// depends on lsse_pkg
`default_nettype none

module lsse_front #(
   parameter int DEPTH = lsse_pkg::QUEUE_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire lsse_pkg::ctrl_vec_type  req_ctrl,
   output lsse_pkg::qhead_type          head,
   input  wire logic                    pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lsse_pkg::ctrl_vec_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop_go;
   logic             full;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign req_stall = full;
   assign push      = req_valid && !full;
   assign pop_go    = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.ctrl  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_go) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop_go})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_ctrl;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/lsse_back.sv
// lsse_back: row sequencer, multiply-accumulate pipeline, euler update and
// state/result register; depends on lsse_pkg
`default_nettype none

module lsse_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire lsse_pkg::qhead_type                  head,
   output logic                                      pop,
   input  wire logic [lsse_pkg::STEP_W-1:0]          step_size,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output lsse_pkg::state_vec_type                   rsp_state
);

   localparam int N = lsse_pkg::NUM_STATES;
   localparam logic [lsse_pkg::ROW_W-1:0] ROW_LAST = lsse_pkg::ROW_W'(N - 1);

   lsse_pkg::seq_type seq_ff, seq_in;
   logic [lsse_pkg::ROW_W-1:0] row_ff, row_in;
   lsse_pkg::ctrl_vec_type     ctrl_ff;
   lsse_pkg::state_vec_type    state_ff, state_in;
   lsse_pkg::state_vec_type    next_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       v1_ff, v2_ff, v3_ff;
   logic [lsse_pkg::ROW_W-1:0] r1_ff, r2_ff, r3_ff;

   logic signed [lsse_pkg::PROD_A_W-1:0] prod_a_ff [N];
   logic signed [lsse_pkg::PROD_A_W-1:0] prod_a_in [N];
   logic signed [lsse_pkg::PROD_B_W-1:0] prod_b_ff [N];
   logic signed [lsse_pkg::PROD_B_W-1:0] prod_b_in [N];
   logic signed [lsse_pkg::DERIV_W-1:0]  deriv;
   logic signed [lsse_pkg::DERIV_W-1:0]  deriv_rnd;
   logic signed [lsse_pkg::D16_W-1:0]    d16_ff, d16_in;
   logic signed [lsse_pkg::STEP_W:0]     step_s;
   logic signed [lsse_pkg::SCALED_W-1:0] scaled_ff, scaled_in;
   logic signed [lsse_pkg::SCALED_W-1:0] scaled_rnd;
   logic signed [lsse_pkg::INC_W-1:0]    inc;
   logic signed [lsse_pkg::TOTAL_W-1:0]  total;
   logic signed [lsse_pkg::STATE_W-1:0]  sat_in;

   logic issue;
   logic out_free;
   logic commit_go;

   assign issue     = (seq_ff == lsse_pkg::ST_ISSUE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit_go = (seq_ff == lsse_pkg::ST_COMMIT) && out_free;
   assign pop       = (seq_ff == lsse_pkg::ST_IDLE) && head.valid;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_state = state_ff;

   // sequencer
   always_comb begin
      seq_in = seq_ff;
      row_in = row_ff;
      unique case (seq_ff)
         lsse_pkg::ST_IDLE: begin
            if (head.valid) begin
               seq_in = lsse_pkg::ST_ISSUE;
               row_in = '0;
            end
         end
         lsse_pkg::ST_ISSUE: begin
            row_in = row_ff + 1'b1;
            if (row_ff == ROW_LAST) begin
               seq_in = lsse_pkg::ST_DRAIN;
            end
         end
         lsse_pkg::ST_DRAIN: begin
            if (v3_ff && (r3_ff == ROW_LAST)) begin
               seq_in = lsse_pkg::ST_COMMIT;
            end
         end
         lsse_pkg::ST_COMMIT: begin
            if (out_free) begin
               seq_in = lsse_pkg::ST_IDLE;
            end
         end
         default: begin
            seq_in = lsse_pkg::ST_IDLE;
         end
      endcase
   end

   // stage 1: one row of A and B against state and controls
   always_comb begin
      for (int c = 0; c < N; c++) begin
         prod_a_in[c] = lsse_pkg::COEF_A[row_ff][c] * $signed(state_ff[c]);
         prod_b_in[c] = lsse_pkg::COEF_B[row_ff][c] * $signed(ctrl_ff[c]);
      end
   end

   // stage 2: row sum in Q.30, round half up to Q.16
   always_comb begin
      deriv = '0;
      for (int c = 0; c < N; c++) begin
         deriv = deriv + lsse_pkg::DERIV_W'(prod_a_ff[c])
               + (lsse_pkg::DERIV_W'(prod_b_ff[c]) <<< lsse_pkg::B_SHIFT);
      end
      deriv_rnd = deriv + lsse_pkg::D_HALF;
      d16_in    = lsse_pkg::D16_W'(deriv_rnd >>> lsse_pkg::D_SHIFT);
   end

   // stage 3: scale by step size
   assign step_s    = $signed({1'b0, step_size});
   assign scaled_in = d16_ff * step_s;

   // stage 4: round, add to state, saturate
   always_comb begin
      scaled_rnd = scaled_ff + lsse_pkg::S_HALF;
      inc        = lsse_pkg::INC_W'(scaled_rnd >>> lsse_pkg::S_SHIFT);
      total      = lsse_pkg::TOTAL_W'($signed(state_ff[r3_ff]))
                 + lsse_pkg::TOTAL_W'(inc);
      if (total > lsse_pkg::SAT_HI) begin
         sat_in = lsse_pkg::STATE_W'(lsse_pkg::SAT_HI);
      end else if (total < lsse_pkg::SAT_LO) begin
         sat_in = lsse_pkg::STATE_W'(lsse_pkg::SAT_LO);
      end else begin
         sat_in = lsse_pkg::STATE_W'(total);
      end
   end

   always_comb begin
      state_in     = commit_go ? next_ff : state_ff;
      rsp_valid_in = commit_go || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= lsse_pkg::ST_IDLE;
         row_ff       <= '0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         row_ff       <= row_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ctrl_ff <= head.ctrl;
      end
      for (int c = 0; c < N; c++) begin
         prod_a_ff[c] <= prod_a_in[c];
         prod_b_ff[c] <= prod_b_in[c];
      end
      r1_ff     <= row_ff;
      r2_ff     <= r1_ff;
      r3_ff     <= r2_ff;
      d16_ff    <= d16_in;
      scaled_ff <= scaled_in;
      if (v3_ff) begin
         next_ff[r3_ff] <= sat_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/linear_state_space_euler_step.sv
// Forward euler step of a four-joint linear state-space model.
// A req word passes through the queue, four row issues through the 8-multiplier
// row unit, three pipeline stages and commit before rsp_valid rises.
// The back end sequencer handles one word at a time: pop, four rows, drain, then
// commit, which waits while a held result is stalled, before the next pop.
// Reset: joint state cleared to zero, step_size to 2185, queue emptied.
`default_nettype none

module linear_state_space_euler_step #(
   parameter int QUEUE_DEPTH = lsse_pkg::QUEUE_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [lsse_pkg::CTRL_W-1:0] req_ctrl_0,
   input  wire logic signed [lsse_pkg::CTRL_W-1:0] req_ctrl_1,
   input  wire logic signed [lsse_pkg::CTRL_W-1:0] req_ctrl_2,
   input  wire logic signed [lsse_pkg::CTRL_W-1:0] req_ctrl_3,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [lsse_pkg::STATE_W-1:0]     rsp_joint_state_0,
   output logic signed [lsse_pkg::STATE_W-1:0]     rsp_joint_state_1,
   output logic signed [lsse_pkg::STATE_W-1:0]     rsp_joint_state_2,
   output logic signed [lsse_pkg::STATE_W-1:0]     rsp_joint_state_3,

   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [lsse_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [lsse_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lsse_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                    csr_pready
);

   logic [lsse_pkg::STEP_W-1:0]    step_size_ff, step_size_in;
   logic [lsse_pkg::CSR_IDX_W-1:0] csr_idx;
   logic                           csr_wr;
   lsse_pkg::ctrl_vec_type         req_word;
   lsse_pkg::qhead_type            head;
   lsse_pkg::state_vec_type        rsp_state;
   logic                           pop;

   // register file
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[lsse_pkg::CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      step_size_in = step_size_ff;
      if (csr_wr && (csr_idx == lsse_pkg::CSR_STEP_SIZE)) begin
         step_size_in = csr_pwdata[lsse_pkg::STEP_W-1:0];
      end
      if (csr_idx == lsse_pkg::CSR_STEP_SIZE) begin
         csr_prdata = lsse_pkg::CSR_DATA_W'(step_size_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= lsse_pkg::STEP_SIZE_RESET;
      end else begin
         step_size_ff <= step_size_in;
      end
   end

   assign req_word = {req_ctrl_3, req_ctrl_2, req_ctrl_1, req_ctrl_0};

   lsse_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_ctrl  (req_word),
      .head      (head),
      .pop       (pop)
   );

   lsse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .step_size (step_size_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_state (rsp_state)
   );

   assign rsp_joint_state_0 = $signed(rsp_state[0]);
   assign rsp_joint_state_1 = $signed(rsp_state[1]);
   assign rsp_joint_state_2 = $signed(rsp_state[2]);
   assign rsp_joint_state_3 = $signed(rsp_state[3]);

endmodule

`default_nettype wire

FILE: tb/sv/tb_linear_state_space_euler_step.sv
// tb_linear_state_space_euler_step: self-checking bench for the forward euler arm step,
// with a built-in predictor of the 4x4 state-space update, random idling and csr phases
// depends on lsse_pkg and linear_state_space_euler_step
module tb_linear_state_space_euler_step;

   localparam int  CYCLE_LIMIT = 500000;
   localparam int  MAX_WAIT    = 12;
   localparam int  HOLD_CYCLES = 80;
   localparam int  END_CYCLES  = 20;
   localparam int  RESET_CYCLES = 9;
   localparam logic [lsse_pkg::CSR_ADDR_W-1:0] ADDR_STEP_SIZE = 3'd0;
   localparam logic [lsse_pkg::CSR_ADDR_W-1:0] ADDR_UNMAPPED  = 3'd4;
   localparam logic [lsse_pkg::STEP_W-1:0]     STEP_DEFAULT   = 16'd2185;
   localparam longint STATE_MAX = 64'sd2147483647;
   localparam longint STATE_MIN = -64'sd2147483648;

   int arm_a [0:3][0:3] = '{
      '{-12625,    -84,   3711,   2959},
      '{   267,  -5795,  -4604,    257},
      '{ -3369,  -1149, -20392,   1519},
      '{ -5192,    772,   -624, -27838}
   };
   int arm_b [0:3][0:3] = '{
      '{ 15788,  -1352,  -2448,   -321},
      '{   185,  16712,   -441,  -1463},
      '{   554,   -177,  31080,   -800},
      '{  2335,    436,  -2310,  33587}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid  = 1'b0;
   logic                                 req_stall;
   logic signed [lsse_pkg::CTRL_W-1:0]   req_ctrl_0 = '0;
   logic signed [lsse_pkg::CTRL_W-1:0]   req_ctrl_1 = '0;
   logic signed [lsse_pkg::CTRL_W-1:0]   req_ctrl_2 = '0;
   logic signed [lsse_pkg::CTRL_W-1:0]   req_ctrl_3 = '0;

   logic                                 rsp_valid;
   logic                                 rsp_stall  = 1'b0;
   logic signed [lsse_pkg::STATE_W-1:0]  rsp_joint_state_0;
   logic signed [lsse_pkg::STATE_W-1:0]  rsp_joint_state_1;
   logic signed [lsse_pkg::STATE_W-1:0]  rsp_joint_state_2;
   logic signed [lsse_pkg::STATE_W-1:0]  rsp_joint_state_3;

   logic                                 csr_psel    = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite  = 1'b0;
   logic [lsse_pkg::CSR_ADDR_W-1:0]      csr_paddr   = '0;
   logic [lsse_pkg::CSR_DATA_W-1:0]      csr_pwdata  = '0;
   logic [lsse_pkg::CSR_DATA_W-1:0]      csr_prdata;
   logic                                 csr_pready;

   lsse_pkg::state_vec_type arm_state = '0;
   logic [lsse_pkg::STEP_W-1:0] step_now = STEP_DEFAULT;
   lsse_pkg::state_vec_type joint_expect [$];
   int  fail_count  = 0;
   int  cycle_count = 0;
   bit  tx_gaps     = 1'b1;
   bit  rx_random   = 1'b1;
   bit  rx_hold_req = 1'b0;

   linear_state_space_euler_step u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ctrl_0        (req_ctrl_0),
      .req_ctrl_1        (req_ctrl_1),
      .req_ctrl_2        (req_ctrl_2),
      .req_ctrl_3        (req_ctrl_3),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_joint_state_0 (rsp_joint_state_0),
      .rsp_joint_state_1 (rsp_joint_state_1),
      .rsp_joint_state_2 (rsp_joint_state_2),
      .rsp_joint_state_3 (rsp_joint_state_3),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // one euler step of the arm: q += round(round(A*q + B*u) * step)
   function automatic lsse_pkg::state_vec_type advance_arm(input lsse_pkg::ctrl_vec_type u);
      lsse_pkg::state_vec_type nxt;
      longint acc;
      longint d16;
      longint inc;
      longint sum;
      for (int r = 0; r < lsse_pkg::NUM_STATES; r++) begin
         acc = 0;
         for (int c = 0; c < lsse_pkg::NUM_STATES; c++) begin
            acc += longint'(arm_a[r][c]) * longint'($signed(arm_state[c]));
            acc += longint'(arm_b[r][c]) * longint'($signed(u[c])) * 4;
         end
         d16 = (acc + 8192) >>> 14;
         inc = (d16 * longint'(step_now) + 32768) >>> 16;
         sum = longint'($signed(arm_state[r])) + inc;
         if (sum > STATE_MAX) begin
            nxt[r] = 32'h7fff_ffff;
         end else if (sum < STATE_MIN) begin
            nxt[r] = 32'h8000_0000;
         end else begin
            nxt[r] = sum[lsse_pkg::STATE_W-1:0];
         end
      end
      arm_state = nxt;
      return nxt;
   endfunction

   function automatic logic [lsse_pkg::CTRL_W-1:0] rand_ctrl();
      logic [lsse_pkg::CTRL_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: v = lsse_pkg::CTRL_W'($urandom_range(0, 32768) - 16384);
         6, 7: v = lsse_pkg::CTRL_W'($urandom);
         8: begin
            case ($urandom_range(0, 5))
               0: v = 16'h8000;
               1: v = 16'h7fff;
               2: v = 16'hc000;
               3: v = 16'h4000;
               4: v = 16'hffff;
               default: v = 16'h0000;
            endcase
         end
         default: v = lsse_pkg::CTRL_W'($urandom_range(0, 64) - 32);
      endcase
      return v;
   endfunction

   task automatic send_word(input lsse_pkg::ctrl_vec_type u);
      int gap;
      lsse_pkg::state_vec_type nxt;
      gap = tx_gaps ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_ctrl_0 <= u[0];
      req_ctrl_1 <= u[1];
      req_ctrl_2 <= u[2];
      req_ctrl_3 <= u[3];
      do @(posedge clock); while (req_stall !== 1'b0);
      nxt = advance_arm(u);
      joint_expect = {joint_expect, nxt};
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (joint_expect.size() != 0);
   endtask

   task automatic csr_write(input logic [lsse_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [lsse_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_STEP_SIZE) begin
         step_now = data[lsse_pkg::STEP_W-1:0];
      end
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [lsse_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [lsse_pkg::STEP_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== lsse_pkg::CSR_DATA_W'(value)) begin
         $error("step_size: expected %0d, actual %0d", value, csr_prdata);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_step(input logic [lsse_pkg::STEP_W-1:0] value);
      drain_results();
      csr_write(ADDR_STEP_SIZE,
                {lsse_pkg::CSR_DATA_W'($urandom_range(0, 65535)) << lsse_pkg::STEP_W} | value);
      csr_check(ADDR_STEP_SIZE, value);
   endtask

   // receiver: per word a random hold-off, or a long hold when requested
   initial begin
      int n;
      do @(posedge clock); while (reset);
      forever begin
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            n = HOLD_CYCLES;
         end else begin
            n = rx_random ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      lsse_pkg::state_vec_type got;
      lsse_pkg::state_vec_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         got = {rsp_joint_state_3, rsp_joint_state_2, rsp_joint_state_1, rsp_joint_state_0};
         if (joint_expect.size() == 0) begin
            $error("unexpected result word: joint states %h", got);
            fail_count++;
         end else begin
            want = joint_expect.pop_front();
            for (int i = 0; i < lsse_pkg::NUM_STATES; i++) begin
               if (got[i] !== want[i]) begin
                  $error("joint_state_%0d: expected %0d, actual %0d",
                         i, $signed(want[i]), $signed(got[i]));
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic test_reset_values();
      csr_check(ADDR_STEP_SIZE, STEP_DEFAULT);
   endtask

   task automatic test_control_extremes();
      lsse_pkg::ctrl_vec_type u;
      send_word('0);
      send_word({4{16'sd16384}});
      send_word({4{-16'sd16384}});
      send_word({4{16'h7fff}});
      send_word({4{16'h8000}});
      for (int i = 0; i < lsse_pkg::NUM_STATES; i++) begin
         u    = '0;
         u[i] = 16'h7fff;
         send_word(u);
      end
      for (int i = 0; i < lsse_pkg::NUM_STATES; i++) begin
         u    = '0;
         u[i] = 16'h8000;
         send_word(u);
      end
      send_word({16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
      send_word({16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
      send_word({4{16'hffff}});
      send_word({16'haaaa, 16'h5555, 16'haaaa, 16'h5555});
   endtask

   task automatic test_step_extremes();
      // zero step holds the state
      set_step(16'd0);
      send_word({4{16'h7fff}});
      send_word({4{16'h8000}});
      set_step(16'hffff);
      send_word({4{16'h7fff}});
      send_word({16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
      set_step(16'd1);
      send_word({4{16'h8000}});
      // write to an unmapped register is ignored
      drain_results();
      csr_write(ADDR_UNMAPPED, $urandom);
      csr_check(ADDR_STEP_SIZE, 16'd1);
      send_word({4{16'h4000}});
   endtask

   task automatic test_backpressure();
      drain_results();
      set_step(STEP_DEFAULT);
      tx_gaps     = 1'b0;
      rx_hold_req = 1'b1;
      repeat (14) send_word({rand_ctrl(), rand_ctrl(), rand_ctrl(), rand_ctrl()});
      drain_results();
      tx_gaps = 1'b1;
   endtask

   task automatic run_phase(input logic [lsse_pkg::STEP_W-1:0] step, input int count,
                            input bit gaps, input bit rx_idle);
      set_step(step);
      tx_gaps   = gaps;
      rx_random = rx_idle;
      repeat (count) send_word({rand_ctrl(), rand_ctrl(), rand_ctrl(), rand_ctrl()});
   endtask

   task automatic test_random_traffic();
      run_phase(STEP_DEFAULT, 300, 1'b1, 1'b1);
      run_phase(16'hffff,     250, 1'b0, 1'b0);
      run_phase(16'd0,        150, 1'b1, 1'b1);
      run_phase(16'd1,        150, 1'b1, 1'b0);
      repeat (4) run_phase(lsse_pkg::STEP_W'($urandom_range(0, 65535)), 260, 1'b1, 1'b1);
      tx_gaps   = 1'b1;
      rx_random = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_control_extremes();
      test_step_extremes();
      test_backpressure();
      test_random_traffic();
      drain_results();
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/lsse_pkg.sv
hw/rtl/lsse_front.sv
hw/rtl/lsse_back.sv
hw/rtl/linear_state_space_euler_step.sv
tb/sv/tb_linear_state_space_euler_step.sv
